FILE: rtl/mebt_pkg.sv
// ----------------------------------------------------------------------------
// mebt_pkg
// Shared types, constants and helpers for the escape-time pixel engine.
// ----------------------------------------------------------------------------
package mebt_pkg;

    localparam int IMAGE_DIM = 1024;
    localparam int FRAC_BITS = 24;
    localparam int IDX_W     = $clog2(IMAGE_DIM);
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int ITER_W    = 16;
    localparam int ESC_W     = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INC_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SQ = 3'd5;

    localparam logic signed [WORD_W-1:0] MIN_X_RST     = -32'sd33554432;
    localparam logic signed [WORD_W-1:0] INC_X_RST     = 32'sd65536;
    localparam logic signed [WORD_W-1:0] MIN_Y_RST     = -32'sd25165824;
    localparam logic signed [WORD_W-1:0] INC_Y_RST     = 32'sd65536;
    localparam logic [ITER_W-1:0]        MAX_ITER_RST  = 16'd256;
    localparam logic [ESC_W-1:0]         ESCAPE_SQ_RST = 31'd268435456;

    localparam logic signed [PROD_W-1:0] WORD_MAX =
        PROD_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] WORD_MIN =
        PROD_W'(-64'sh0000_0000_8000_0000);

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } pixel_t;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              in_set;
    } result_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] min_x;
        logic signed [WORD_W-1:0] inc_x;
        logic signed [WORD_W-1:0] min_y;
        logic signed [WORD_W-1:0] inc_y;
        logic [ITER_W-1:0]        max_iter;
        logic [ESC_W-1:0]         escape_sq;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } mul_req_t;

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX)
            r = WORD_MAX[WORD_W-1:0];
        else if (v < WORD_MIN)
            r = WORD_MIN[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/mandelbrot_escape_time_pixel_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time engine for one pixel of the Mandelbrot set in Q8.24.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low. busy then stays high
// until the last update has been tested. The number n of updates tested is
// iterations+1 for an escaping point, max_iter for a point inside the set (n = 0 when
// max_iter is 0). Each update uses the single shared 32x32 multiplier,
// which forms re*re, im*im and re*im in turn; then the bound is tested and
// c is added for the next update. The result word appears for one cycle
// with done high, in the same cycle that busy falls; the receiver cannot
// stall it, and a new pixel may start in that same cycle.
module mandelbrot_escape_time_pixel_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mebt_pkg::pixel_t                 pixel,
    output logic                             done,
    output mebt_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [mebt_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [mebt_pkg::WORD_W-1:0]      cfg_data
);

    mebt_pkg::cfg_t                      cfg;
    mebt_pkg::mul_req_t                  req;
    logic signed [mebt_pkg::PROD_W-1:0]  prod;

    mebt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    mebt_mul u_mul (
        .clk  (clk),
        .req  (req),
        .prod (prod)
    );

    mebt_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .pixel  (pixel),
        .cfg    (cfg),
        .prod   (prod),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule

FILE: rtl/mebt_cfg.sv
// ----------------------------------------------------------------------------
// mebt_cfg
// Configuration register file: view window, step sizes and escape limits.
// ----------------------------------------------------------------------------
module mebt_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mebt_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [mebt_pkg::WORD_W-1:0]      cfg_data,
    output mebt_pkg::cfg_t                   cfg
);

    mebt_pkg::cfg_t cfg_reg;
    mebt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                mebt_pkg::REG_MIN_X:     cfg_next.min_x     = cfg_data;
                mebt_pkg::REG_INC_X:     cfg_next.inc_x     = cfg_data;
                mebt_pkg::REG_MIN_Y:     cfg_next.min_y     = cfg_data;
                mebt_pkg::REG_INC_Y:     cfg_next.inc_y     = cfg_data;
                mebt_pkg::REG_MAX_ITER:
                    cfg_next.max_iter  = cfg_data[mebt_pkg::ITER_W-1:0];
                mebt_pkg::REG_ESCAPE_SQ:
                    cfg_next.escape_sq = cfg_data[mebt_pkg::ESC_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x     <= mebt_pkg::MIN_X_RST;
            cfg_reg.inc_x     <= mebt_pkg::INC_X_RST;
            cfg_reg.min_y     <= mebt_pkg::MIN_Y_RST;
            cfg_reg.inc_y     <= mebt_pkg::INC_Y_RST;
            cfg_reg.max_iter  <= mebt_pkg::MAX_ITER_RST;
            cfg_reg.escape_sq <= mebt_pkg::ESCAPE_SQ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/mebt_mul.sv
// ----------------------------------------------------------------------------
// mebt_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mebt_mul (
    input  logic                                clk,
    input  mebt_pkg::mul_req_t                  req,
    output logic signed [mebt_pkg::PROD_W-1:0]  prod
);

    logic signed [mebt_pkg::PROD_W-1:0] prod_reg;
    logic signed [mebt_pkg::PROD_W-1:0] prod_next;

    assign prod_next = mebt_pkg::PROD_W'(req.a) * mebt_pkg::PROD_W'(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/mebt_seq.sv
// ----------------------------------------------------------------------------
// mebt_seq
// Iteration sequencer: forms c, steps z = z*z + c on the shared multiplier,
// tests the escape bound and issues the result word.
// ----------------------------------------------------------------------------
module mebt_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  mebt_pkg::pixel_t                    pixel,
    input  mebt_pkg::cfg_t                      cfg,
    input  logic signed [mebt_pkg::PROD_W-1:0]  prod,
    output mebt_pkg::mul_req_t                  req,
    output logic                                busy,
    output logic                                done,
    output mebt_pkg::result_t                   result
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_C_RE   = 9'b000000010,
        S_C_IM   = 9'b000000100,
        S_Z_INIT = 9'b000001000,
        S_UPDATE = 9'b000010000,
        S_SQ_RE  = 9'b000100000,
        S_SQ_IM  = 9'b001000000,
        S_CROSS  = 9'b010000000,
        S_CHECK  = 9'b100000000
    } state_t;

    localparam int W = mebt_pkg::WORD_W;
    localparam int P = mebt_pkg::PROD_W;

    state_t                          state_reg, state_next;
    logic                            done_reg, done_next;
    mebt_pkg::result_t               result_reg, result_next;
    logic [mebt_pkg::ITER_W-1:0]     k_reg, k_next;
    logic [mebt_pkg::IDX_W-1:0]      row_reg, row_next;
    logic [mebt_pkg::IDX_W-1:0]      col_reg, col_next;
    logic signed [W-1:0]             c_re_reg, c_re_next;
    logic signed [W-1:0]             c_im_reg, c_im_next;
    logic signed [W-1:0]             re_reg, re_next;
    logic signed [W-1:0]             im_reg, im_next;
    logic signed [P-1:0]             rr_reg, rr_next;
    logic signed [P-1:0]             ii_reg, ii_next;
    logic signed [P-1:0]             ri_reg, ri_next;

    logic signed [P-1:0]             coord_sum;
    logic signed [P-1:0]             re_sum;
    logic signed [P-1:0]             im_sum;
    logic [P-1:0]                    mag;
    logic [P-1:0]                    bound;
    logic [mebt_pkg::ITER_W-1:0]     k_inc;

    assign coord_sum = prod + P'(state_reg == S_C_IM ? cfg.min_x : cfg.min_y);
    assign re_sum    = ((rr_reg - ii_reg) >>> mebt_pkg::FRAC_BITS) + P'(c_re_reg);
    assign im_sum    = (ri_reg >>> (mebt_pkg::FRAC_BITS - 1)) + P'(c_im_reg);
    assign mag       = unsigned'(rr_reg) + unsigned'(ii_reg);
    assign bound     = P'(cfg.escape_sq) << mebt_pkg::FRAC_BITS;
    assign k_inc     = k_reg + mebt_pkg::ITER_W'(1);

    always_comb
    begin
        req.a = '0;
        req.b = '0;
        case (state_reg)
            S_C_RE:
            begin
                req.a = W'(row_reg);
                req.b = cfg.inc_x;
            end
            S_C_IM:
            begin
                req.a = W'(col_reg);
                req.b = cfg.inc_y;
            end
            S_SQ_RE:
            begin
                req.a = re_reg;
                req.b = re_reg;
            end
            S_SQ_IM:
            begin
                req.a = im_reg;
                req.b = im_reg;
            end
            S_CROSS:
            begin
                req.a = re_reg;
                req.b = im_reg;
            end
            default:
            begin
                req.a = '0;
                req.b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        k_next      = k_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        rr_next     = rr_reg;
        ii_next     = ii_reg;
        ri_next     = ri_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    row_next   = pixel.row[mebt_pkg::IDX_W-1:0];
                    col_next   = pixel.col[mebt_pkg::IDX_W-1:0];
                    k_next     = '0;
                    state_next = S_C_RE;
                end
            end
            S_C_RE:
            begin
                state_next = S_C_IM;
            end
            S_C_IM:
            begin
                c_re_next  = mebt_pkg::sat_word(coord_sum);
                state_next = S_Z_INIT;
            end
            S_Z_INIT:
            begin
                c_im_next = mebt_pkg::sat_word(coord_sum);
                rr_next   = '0;
                ii_next   = '0;
                ri_next   = '0;
                if (cfg.max_iter == '0)
                begin
                    done_next              = 1'b1;
                    result_next.iterations = '0;
                    result_next.in_set     = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                re_next    = mebt_pkg::sat_word(re_sum);
                im_next    = mebt_pkg::sat_word(im_sum);
                state_next = S_SQ_RE;
            end
            S_SQ_RE:
            begin
                state_next = S_SQ_IM;
            end
            S_SQ_IM:
            begin
                rr_next    = prod;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                ii_next    = prod;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ri_next = prod;
                if (mag > bound)
                begin
                    done_next              = 1'b1;
                    result_next.iterations = k_reg;
                    result_next.in_set     = 1'b0;
                    state_next             = S_IDLE;
                end
                else if (k_inc == cfg.max_iter)
                begin
                    done_next              = 1'b1;
                    result_next.iterations = k_inc;
                    result_next.in_set     = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_UPDATE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        k_reg      <= k_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        ri_reg     <= ri_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while engine busy");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_CHECK || $past(state_reg) == S_Z_INIT)
        else $error("result strobe from unexpected step");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && state_reg == S_IDLE |=> state_reg == S_C_RE && !done_reg)
        else $error("accepted pixel did not launch");

    a_check_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> $past(state_reg) == S_CROSS)
        else $error("escape test without fresh squares");
`endif

endmodule
